/* design/maef_pkg.sv */
// ----------------------------------------------------------------------------
// Multichannel converter smoother package
// Shared word types, widths, constants and sequencer states of the
// exponential moving average filter.
// ----------------------------------------------------------------------------
package maef_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W = 12;
   localparam int CHAN_W   = 4;
   localparam int DIV_W    = 5;

   // Numerator sample + old * (K - 1) stays below 4095 * 32.
   localparam int NUMER_W = SAMPLE_W + DIV_W;

   // Defaults.
   localparam int              CHANNELS_DEFAULT = 12;
   localparam logic [DIV_W-1:0] DIVISOR_RESET   = 5'd10;
   localparam logic [3:0]       SAMPLE_HI_MASK  = 4'hf;

   // Input word: one converter result as a byte pair.
   typedef struct packed {
      logic [7:0] high_byte;
      logic [7:0] low_byte;
      logic       scan_start;
   } req_word_type;

   // Result word: the updated channel average.
   typedef struct packed {
      logic [CHAN_W-1:0]   channel_index;
      logic [SAMPLE_W-1:0] filtered_value;
      logic                scan_last;
   } rsp_word_type;

   // Control and status between the sequencer and the divider.
   typedef struct packed {
      logic                start;
      logic [NUMER_W-1:0]  dividend;
      logic [DIV_W-1:0]    divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [NUMER_W-1:0]  quotient;
   } div_stat_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

endpackage

/* design/multichannel_adc_ema_filter.sv */
// ----------------------------------------------------------------------------
// Multichannel converter smoother
// Exponential moving average per channel over a scan of converter results.
// ----------------------------------------------------------------------------
// Each input word carries one 12-bit converter result as a byte pair and a
// scan-start flag. A channel counter, restarted by scan-start and wrapping
// after the last channel, picks the channel. That channel's average becomes
// (sample + old * (K - 1)) / K, rounded down, with K from the divisor register
// (zero acts as one). The result word returns the channel, the new average
// and a last-of-scan mark.
// When the receiver does not stall, a word passes these steps between one
// accept and the next. The accepting idle state is followed by the multiply
// state, which reads the average and forms the numerator. Then the bit-serial
// divider runs (one quotient bit per cycle) and the divide state sees it
// finish. Last, the write state writes back and loads the result.
// req_stall is high while a word is in work. The result sits in an output
// register, so the next input word is taken while it waits; if the receiver
// still stalls when the following result is ready, the sequencer holds.
// Reset clears all channel averages, the channel counter, the result valid
// and sets the divisor to ten. The divisor must be written only while idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_adc_ema_filter
   import maef_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word,
   input  logic             csr_write,
   input  logic [DIV_W-1:0] csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   state_type           state_ff, state_in;
   logic [DIV_W-1:0]    divisor_ff;
   logic [CHAN_W-1:0]   next_ch_ff;
   logic [CHAN_W-1:0]   ch_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] average_ff [CHANNELS];
   logic                rsp_valid_ff;
   rsp_word_type        rsp_word_ff;

   logic                req_take;
   logic                slot_free;
   logic                write_en;
   logic                div_start;
   logic [CHAN_W-1:0]   ch_pick;
   logic [CHAN_W-1:0]   ch_sel;
   logic                ch_last;
   logic [DIV_W-1:0]    k_eff;
   logic [DIV_W-1:0]    k_less;
   logic [SAMPLE_W-1:0] old_avg;
   logic [SAMPLE_W-1:0] new_avg;
   div_cmd_type         div_cmd;
   div_stat_type        div_stat;

   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Channel for the incoming word, wrapped into range.
   always_comb begin
      ch_pick = req_word.scan_start ? '0 : next_ch_ff;
      ch_sel  = ({1'b0, ch_pick} >= (CHAN_W + 1)'(CHANNELS)) ? '0 : ch_pick;
   end

   assign ch_last = (ch_ff == CHAN_W'(CHANNELS - 1));

   // Numerator: one multiply and add, registered in the divider.
   assign k_eff   = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;
   assign k_less  = k_eff - 1'b1;
   assign old_avg = average_ff[ch_ff[IDX_W-1:0]];
   assign new_avg = div_stat.quotient[SAMPLE_W-1:0];

   always_comb begin
      div_cmd.start    = div_start;
      div_cmd.dividend = NUMER_W'(sample_ff) + NUMER_W'(old_avg) * NUMER_W'(k_less);
      div_cmd.divisor  = k_eff;
   end

   maef_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MULT;
         ST_MULT:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_stat.done) state_in = ST_WRITE;
         ST_WRITE:  if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      write_en  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_MULT:   div_start = 1'b1;
         ST_DIVIDE: req_stall = 1'b1;
         ST_WRITE:  write_en = slot_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         divisor_ff   <= DIVISOR_RESET;
         next_ch_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            divisor_ff <= csr_data;
         end
         if (write_en) begin
            next_ch_ff   <= ch_last ? '0 : ch_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Average store, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            average_ff[i] <= '0;
         end
      end else if (write_en) begin
         average_ff[ch_ff[IDX_W-1:0]] <= new_avg;
      end
   end

   // Word capture and result register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff     <= ch_sel;
         sample_ff <= {req_word.high_byte[3:0] & SAMPLE_HI_MASK, req_word.low_byte};
      end
      if (write_en) begin
         rsp_word_ff.channel_index  <= ch_ff;
         rsp_word_ff.filtered_value <= new_avg;
         rsp_word_ff.scan_last      <= ch_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // An accepted word keeps the input side stalled in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepting a word");

   // Results name a channel in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_word.channel_index} < (CHAN_W + 1)'(CHANNELS)))
      else $error("result channel out of range");

   // The last-of-scan mark matches the final channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_word.scan_last == (rsp_word.channel_index == CHAN_W'(CHANNELS - 1))))
      else $error("last-of-scan mark does not match channel");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside the divide state");

endmodule

/* design/maef_div.sv */
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module maef_div
   import maef_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   localparam int CNT_W = $clog2(NUMER_W + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               done_ff, done_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [NUMER_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]   den_ff, den_in;
   logic [DIV_W:0]     trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial    = {rem_ff, quo_ff[NUMER_W-1]};
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (cmd.start) begin
         count_in = CNT_W'(NUMER_W);
         rem_in   = '0;
         quo_in   = cmd.dividend;
         den_in   = cmd.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUMER_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[NUMER_W-2:0], 1'b0};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

/* verif/multichannel_adc_ema_filter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel converter smoother testbench
// Drives converter byte pairs into the per-channel moving average filter and
// checks every result word against a cycle-free shadow of the filter state.
// Directed words cover sample extremes, ignored upper bits, short and long
// scans and divisor extremes. Random scans then run under three mixes of
// sender gaps and receiver stalls, with divisor changes between blocks.
// ----------------------------------------------------------------------------
module multichannel_adc_ema_filter_tb;
   import maef_pkg::*;

   localparam int NUM_CHANNELS = CHANNELS_DEFAULT;
   localparam int DRAIN_CYCLES = 30;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int BLOCK_WORDS  = 61;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_word_type     req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_write = 1'b0;
   logic [DIV_W-1:0] csr_data = '0;

   // Shadow of the filter state.
   logic [SAMPLE_W-1:0] shadow_average [NUM_CHANNELS];
   int unsigned         shadow_channel;
   logic [DIV_W-1:0]    shadow_divisor;

   rsp_word_type pending_averages [$];
   int           send_idle_pct;
   int           recv_idle_pct;
   int           failures;
   int           cycle_count;

   multichannel_adc_ema_filter #(
      .CHANNELS (NUM_CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Updates the shadow average of the addressed channel and returns the
   // result word the filter must produce for this input word.
   function automatic rsp_word_type smooth_sample(req_word_type w);
      int unsigned  sample;
      int unsigned  k;
      int unsigned  chan;
      int unsigned  numer;
      rsp_word_type r;
      sample = {w.high_byte[3:0], w.low_byte};
      k = (shadow_divisor == '0) ? 1 : int'(shadow_divisor);
      chan = w.scan_start ? 0 : shadow_channel;
      if (chan >= NUM_CHANNELS) begin
         chan = 0;
      end
      numer = sample + shadow_average[chan] * (k - 1);
      shadow_average[chan] = SAMPLE_W'(numer / k);
      r.channel_index  = CHAN_W'(chan);
      r.filtered_value = shadow_average[chan];
      r.scan_last      = (chan == NUM_CHANNELS - 1);
      shadow_channel   = r.scan_last ? 0 : chan + 1;
      return r;
   endfunction

   function automatic req_word_type random_word(logic scan_start);
      req_word_type w;
      w.high_byte  = 8'($urandom_range(255));
      w.low_byte   = 8'($urandom_range(255));
      w.scan_start = scan_start;
      // Now and then force a full-scale or zero sample.
      case ($urandom_range(9))
         0: begin
            w.high_byte[3:0] = 4'hf;
            w.low_byte       = 8'hff;
         end
         1: begin
            w.high_byte[3:0] = 4'h0;
            w.low_byte       = 8'h00;
         end
         default: ;
      endcase
      return w;
   endfunction

   // Offers one word, with a random gap first, and records its expected
   // result once the filter takes it.
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_averages.push_back(smooth_sample(w));
   endtask

   // Drops valid and waits until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The filter is idle whenever this is called.
   task automatic write_divisor(logic [DIV_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      shadow_divisor = value;
   endtask

   // Receiver stall, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, rsp_word);
            failures++;
         end else begin
            rsp_word_type exp_word;
            exp_word = pending_averages.pop_front();
            if (rsp_word.channel_index !== exp_word.channel_index) begin
               $display("%0t: channel_index expected %0d actual %0d", $time,
                        exp_word.channel_index, rsp_word.channel_index);
               failures++;
            end
            if (rsp_word.filtered_value !== exp_word.filtered_value) begin
               $display("%0t: filtered_value expected %0d actual %0d", $time,
                        exp_word.filtered_value, rsp_word.filtered_value);
               failures++;
            end
            if (rsp_word.scan_last !== exp_word.scan_last) begin
               $display("%0t: scan_last expected %0d actual %0d", $time,
                        exp_word.scan_last, rsp_word.scan_last);
               failures++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Reset divisor, extreme samples, ignored upper nibble and a short scan.
   task automatic test_default_divisor();
      send_word('{high_byte: 8'hff, low_byte: 8'hff, scan_start: 1'b1});
      send_word('{high_byte: 8'hf0, low_byte: 8'h00, scan_start: 1'b0});
      send_word('{high_byte: 8'h0a, low_byte: 8'hbc, scan_start: 1'b1});
      send_word('{high_byte: 8'h51, low_byte: 8'h23, scan_start: 1'b0});
      drain();
   endtask

   // Divisor zero acts as one; one, sixteen and thirty-one, the largest.
   task automatic test_divisor_extremes();
      write_divisor(5'd0);
      send_word('{high_byte: 8'h05, low_byte: 8'ha5, scan_start: 1'b1});
      send_word('{high_byte: 8'hff, low_byte: 8'hff, scan_start: 1'b0});
      drain();
      write_divisor(5'd1);
      send_word('{high_byte: 8'h00, low_byte: 8'h00, scan_start: 1'b0});
      drain();
      write_divisor(5'd16);
      send_word('{high_byte: 8'h0f, low_byte: 8'hff, scan_start: 1'b1});
      send_word('{high_byte: 8'h0f, low_byte: 8'hff, scan_start: 1'b1});
      drain();
      write_divisor(5'd31);
      send_word('{high_byte: 8'h0f, low_byte: 8'hff, scan_start: 1'b0});
      send_word('{high_byte: 8'h00, low_byte: 8'h00, scan_start: 1'b1});
      drain();
   endtask

   // A scan longer than the channel count wraps to channel zero.
   task automatic test_scan_wrap();
      write_divisor(5'd2);
      for (int i = 0; i < NUM_CHANNELS + 1; i++) begin
         send_word(random_word(i == 0));
      end
      drain();
   endtask

   // Random scans, mostly full length, with divisor changes between blocks.
   task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
      int sent;
      int scan_len;
      int block_left;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      sent = 0;
      block_left = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 7) begin
            scan_len = NUM_CHANNELS;
         end else begin
            scan_len = $urandom_range(20, 1);
         end
         for (int i = 0; i < scan_len && sent < count; i++) begin
            if (block_left == 0) begin
               drain();
               case ($urandom_range(5))
                  0: write_divisor(5'd0);
                  1: write_divisor(5'd31);
                  2: write_divisor(5'd16);
                  default: write_divisor(DIV_W'($urandom_range(31)));
               endcase
               block_left = BLOCK_WORDS;
            end
            send_word(random_word(i == 0));
            sent++;
            block_left--;
         end
      end
      drain();
   endtask

   initial begin
      failures       = 0;
      cycle_count    = 0;
      send_idle_pct  = 19;
      recv_idle_pct  = 52;
      shadow_channel = 0;
      shadow_divisor = DIVISOR_RESET;
      foreach (shadow_average[i]) begin
         shadow_average[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_divisor();
      test_divisor_extremes();
      test_scan_wrap();
      test_random_traffic(19, 52, 184);
      test_random_traffic(52, 19, 183);
      test_random_traffic(0, 0, 183);

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/maef_pkg.sv
design/maef_div.sv
design/multichannel_adc_ema_filter.sv
verif/multichannel_adc_ema_filter_tb.sv
